@@ rtl/msfr_pkg.sv @@
// Shared types, codes and constants of the motor status frame receiver.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package msfr_pkg;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_COMMAND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_LENGTH  = 2'd1;
    localparam logic [7:0] EXPECTED_COMMAND_RST = 8'd1;
    localparam logic [7:0] EXPECTED_LENGTH_RST  = 8'd64;

    // Frame geometry and default motor count.
    localparam int MOTORS_DEFAULT = 12;
    localparam int RECORD_BYTES   = 5;
    localparam int IDX_OUT_W      = 4;

    // Depth of the queue between the front and back halves.
    localparam int QUEUE_DEPTH = 4;

    // Frame status codes.
    localparam logic [1:0] FS_GOOD = 2'd0;
    localparam logic [1:0] FS_HDR  = 2'd1;
    localparam logic [1:0] FS_CRC  = 2'd2;

    // Operation codes passed from the front to the back.
    localparam logic [1:0] OP_POS = 2'd0;
    localparam logic [1:0] OP_CUR = 2'd1;
    localparam logic [1:0] OP_END = 2'd2;

    // Reflected form of the CRC-16/ARC polynomial 0x8005.
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

    // One queued operation; the record address travels beside it.
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] data;
        logic [1:0]  status;
    } t_op;

    // Feed one byte into a reflected CRC-16, least significant bit first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/msfr_if.sv @@
// Valid/ready channel interfaces of the motor status frame receiver.
// Depends on msfr_pkg for the configuration index and motor index widths.
`default_nettype none

// Received byte stream.
interface msfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

// Decoded motor records and error results.
interface msfr_rec_if;
    logic                               valid;
    logic                               ready;
    logic [msfr_pkg::IDX_OUT_W-1:0]     motor_index;
    logic signed [15:0]                 position_raw;
    logic signed [15:0]                 current_raw;
    logic [1:0]                         frame_status;
    logic                               last_of_frame;
    modport source (output valid, output motor_index, output position_raw,
                    output current_raw, output frame_status, output last_of_frame,
                    input ready);
    modport sink (input valid, input motor_index, input position_raw,
                  input current_raw, input frame_status, input last_of_frame,
                  output ready);
endinterface

// Configuration register writes.
interface msfr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [msfr_pkg::CFG_IDX_W-1:0]   index;
    logic [7:0]                       data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/msfr_front.sv @@
// Front half: counts bytes into frames, runs the CRC and header checks and
// queues record writes and frame-end operations. Depends on msfr_pkg, msfr_if.
`default_nettype none

module msfr_front #(
    parameter int MOTORS = msfr_pkg::MOTORS_DEFAULT,
    parameter int MIDX_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    msfr_byte_if.sink              i_byte,
    msfr_cfg_if.sink               i_cfg,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output msfr_pkg::t_op          o_op,
    output logic [MIDX_W-1:0]      o_addr
);

    localparam int FRAME_BYTES = 4 + msfr_pkg::RECORD_BYTES * MOTORS;
    localparam int POS_W       = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] DATA_END = POS_W'(FRAME_BYTES - 2);

    logic [7:0]        r_exp_cmd;
    logic [7:0]        r_exp_len;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [15:0]       r_crc, n_crc;
    logic              r_hdr_ok, n_hdr_ok;
    logic [2:0]        r_field, n_field;
    logic [MIDX_W-1:0] r_motor, n_motor;
    logic [7:0]        r_pend, n_pend;
    logic [7:0]        r_crc_lo, n_crc_lo;
    logic              accept;
    logic [7:0]        b;
    logic [15:0]       rx_crc;

    assign i_byte.ready = !i_q_full;
    assign i_cfg.ready  = 1'b1;
    assign accept       = i_byte.valid && i_byte.ready;
    assign b            = i_byte.rx_byte;
    assign rx_crc       = {b, r_crc_lo};

    // Configuration registers; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_cmd <= msfr_pkg::EXPECTED_COMMAND_RST;
            r_exp_len <= msfr_pkg::EXPECTED_LENGTH_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                msfr_pkg::REG_EXPECTED_COMMAND: r_exp_cmd <= i_cfg.data;
                msfr_pkg::REG_EXPECTED_LENGTH:  r_exp_len <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // Byte classification and the operation it pushes, if any.
    always_comb begin
        n_pos    = r_pos;
        n_crc    = r_crc;
        n_hdr_ok = r_hdr_ok;
        n_field  = r_field;
        n_motor  = r_motor;
        n_pend   = r_pend;
        n_crc_lo = r_crc_lo;
        o_push   = 1'b0;
        o_op     = '{kind: msfr_pkg::OP_END, data: {r_pend, b}, status: msfr_pkg::FS_GOOD};
        o_addr   = r_motor;
        if (accept) begin
            if (r_pos < DATA_END) begin
                n_crc = msfr_pkg::crc_feed(r_crc, b);
                n_pos = r_pos + 1'b1;
                if (r_pos == POS_W'(0) && b != r_exp_cmd) begin
                    n_hdr_ok = 1'b0;
                end
                if (r_pos == POS_W'(1) && b != r_exp_len) begin
                    n_hdr_ok = 1'b0;
                end
                if (r_pos >= POS_W'(2)) begin
                    // Walk the five bytes of each motor record.
                    case (r_field)
                        3'd1, 3'd3: n_pend = b;
                        3'd2: begin
                            o_push      = 1'b1;
                            o_op.kind   = msfr_pkg::OP_POS;
                        end
                        3'd4: begin
                            o_push      = 1'b1;
                            o_op.kind   = msfr_pkg::OP_CUR;
                        end
                        default: ;
                    endcase
                    if (r_field == 3'd4) begin
                        n_field = 3'd0;
                        n_motor = r_motor + 1'b1;
                    end else begin
                        n_field = r_field + 3'd1;
                    end
                end
            end else if (r_pos == DATA_END) begin
                n_crc_lo = b;
                n_pos    = r_pos + 1'b1;
            end else begin
                // Last byte: report the frame and restart.
                o_push = 1'b1;
                o_op.kind = msfr_pkg::OP_END;
                if (!r_hdr_ok) begin
                    o_op.status = msfr_pkg::FS_HDR;
                end else if (rx_crc != r_crc) begin
                    o_op.status = msfr_pkg::FS_CRC;
                end else begin
                    o_op.status = msfr_pkg::FS_GOOD;
                end
                n_pos    = '0;
                n_crc    = '0;
                n_hdr_ok = 1'b1;
                n_field  = '0;
                n_motor  = '0;
            end
        end
    end

    // Frame tracking state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_crc    <= '0;
            r_hdr_ok <= 1'b1;
            r_field  <= '0;
            r_motor  <= '0;
        end else begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_hdr_ok <= n_hdr_ok;
            r_field  <= n_field;
            r_motor  <= n_motor;
        end
    end

    // Byte holding registers; always written before they are used.
    always_ff @(posedge i_clk) begin
        r_pend   <= n_pend;
        r_crc_lo <= n_crc_lo;
    end

endmodule

`default_nettype wire

@@ rtl/msfr_queue.sv @@
// Small first-in first-out queue between the front and back halves.
// Depends on msfr_pkg for its default depth.
`default_nettype none

module msfr_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = msfr_pkg::QUEUE_DEPTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    output logic                   o_valid,
    output logic [DATA_W-1:0]      o_data,
    input  wire logic              i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/msfr_back.sv @@
// Back half: record memory, frame-end handling and the result output register.
// Depends on msfr_pkg and msfr_if.
`default_nettype none

module msfr_back #(
    parameter int MOTORS = msfr_pkg::MOTORS_DEFAULT,
    parameter int MIDX_W = 4
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire msfr_pkg::t_op     i_op,
    input  wire logic [MIDX_W-1:0] i_addr,
    output logic                   o_pop,
    msfr_rec_if.source             o_rec
);

    localparam int CNT_W = $clog2(MOTORS + 1);
    localparam logic BK_IDLE = 1'b0;
    localparam logic BK_EMIT = 1'b1;

    logic [15:0]       r_pos_mem [MOTORS];
    logic [15:0]       r_cur_mem [MOTORS];
    logic              r_state, n_state;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_rd_valid, n_rd_valid;
    logic [MIDX_W-1:0] r_rd_idx, n_rd_idx;
    logic [15:0]       r_rd_pos;
    logic [15:0]       r_rd_cur;
    logic              r_out_valid, n_out_valid;
    logic [msfr_pkg::IDX_OUT_W-1:0] r_out_idx, n_out_idx;
    logic [15:0]       r_out_pos, n_out_pos;
    logic [15:0]       r_out_cur, n_out_cur;
    logic [1:0]        r_out_status, n_out_status;
    logic              r_out_last, n_out_last;
    logic              out_free;
    logic              we_pos;
    logic              we_cur;
    logic              rd_en;
    logic              load;
    logic              rec_last;

    assign out_free = !r_out_valid || o_rec.ready;
    assign rec_last = r_rd_idx == MIDX_W'(MOTORS - 1);

    assign o_rec.valid         = r_out_valid;
    assign o_rec.motor_index   = r_out_idx;
    assign o_rec.position_raw  = r_out_pos;
    assign o_rec.current_raw   = r_out_cur;
    assign o_rec.frame_status  = r_out_status;
    assign o_rec.last_of_frame = r_out_last;

    // Operation sequencing and record streaming.
    always_comb begin
        n_state      = r_state;
        n_issue      = r_issue;
        n_rd_valid   = r_rd_valid;
        n_rd_idx     = r_rd_idx;
        n_out_valid  = r_out_valid && !o_rec.ready;
        n_out_idx    = r_out_idx;
        n_out_pos    = r_out_pos;
        n_out_cur    = r_out_cur;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        we_pos       = 1'b0;
        we_cur       = 1'b0;
        rd_en        = 1'b0;
        load         = 1'b0;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    case (i_op.kind)
                        msfr_pkg::OP_POS: begin
                            we_pos = 1'b1;
                            o_pop  = 1'b1;
                        end
                        msfr_pkg::OP_CUR: begin
                            we_cur = 1'b1;
                            o_pop  = 1'b1;
                        end
                        msfr_pkg::OP_END: begin
                            if (i_op.status != msfr_pkg::FS_GOOD) begin
                                // Bad frame: a single error result.
                                if (out_free) begin
                                    o_pop        = 1'b1;
                                    n_out_valid  = 1'b1;
                                    n_out_idx    = '0;
                                    n_out_pos    = '0;
                                    n_out_cur    = '0;
                                    n_out_status = i_op.status;
                                    n_out_last   = 1'b1;
                                end
                            end else begin
                                o_pop      = 1'b1;
                                n_state    = BK_EMIT;
                                n_issue    = '0;
                                n_rd_valid = 1'b0;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                end
            end
            BK_EMIT: begin
                // Move a fetched record into the output register.
                load = r_rd_valid && out_free;
                if (load) begin
                    n_out_valid  = 1'b1;
                    n_out_idx    = msfr_pkg::IDX_OUT_W'(r_rd_idx);
                    n_out_pos    = r_rd_pos;
                    n_out_cur    = r_rd_cur;
                    n_out_status = msfr_pkg::FS_GOOD;
                    n_out_last   = rec_last;
                    n_rd_valid   = 1'b0;
                end
                // Fetch the next record when the read register frees up.
                if ((!r_rd_valid || load) && r_issue < CNT_W'(MOTORS)) begin
                    rd_en      = 1'b1;
                    n_rd_valid = 1'b1;
                    n_rd_idx   = r_issue[MIDX_W-1:0];
                    n_issue    = r_issue + 1'b1;
                end
                if (load && rec_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Record memory: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (we_pos) begin
            r_pos_mem[i_addr] <= i_op.data;
        end
        if (we_cur) begin
            r_cur_mem[i_addr] <= i_op.data;
        end
        if (rd_en) begin
            r_rd_pos <= r_pos_mem[r_issue[MIDX_W-1:0]];
            r_rd_cur <= r_cur_mem[r_issue[MIDX_W-1:0]];
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_issue     <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issue     <= n_issue;
            r_rd_valid  <= n_rd_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_out_idx    <= n_out_idx;
        r_out_pos    <= n_out_pos;
        r_out_cur    <= n_out_cur;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

endmodule

`default_nettype wire

@@ rtl/motor_status_frame_receiver_core.sv @@
// Motor status frame receiver: top level joining front, queue and back.
// Depends on msfr_pkg, msfr_if, msfr_front, msfr_queue and msfr_back.
//
// Takes one frame byte per cycle on i_byte and checks each frame of
// 4 + 5*MOTORS bytes (command, length, one five-byte record per motor,
// CRC-16/ARC low byte first). A good frame yields MOTORS results on o_rec,
// one per cycle while the sink takes them, the last one marked; a header or
// CRC mismatch yields one error result, header errors taking precedence.
// Bytes are taken at one per cycle as long as the four-entry operation queue
// has room; every record costs the back half two memory writes and a good
// frame's results stream out of the record memory at one per cycle after a
// registered read, so the front stalls only while the back is still emitting
// the previous frame or the output is held by the sink. The record memory
// needs no clearing pass after reset. Configuration writes on i_cfg are
// always taken and belong between frames.
`default_nettype none

module motor_status_frame_receiver_core #(
    parameter int MOTORS = msfr_pkg::MOTORS_DEFAULT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    msfr_byte_if.sink  i_byte,
    msfr_cfg_if.sink   i_cfg,
    msfr_rec_if.source o_rec
);

    localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int OP_W   = $bits(msfr_pkg::t_op);
    localparam int QW     = OP_W + MIDX_W;

    logic              q_full;
    logic              push;
    msfr_pkg::t_op     push_op;
    logic [MIDX_W-1:0] push_addr;
    logic              q_valid;
    logic [QW-1:0]     q_data;
    logic              pop;
    msfr_pkg::t_op     head_op;
    logic [MIDX_W-1:0] head_addr;

    assign head_op   = msfr_pkg::t_op'(q_data[OP_W-1:0]);
    assign head_addr = q_data[QW-1:OP_W];

    // Byte counting, CRC and header checks.
    msfr_front #(
        .MOTORS (MOTORS),
        .MIDX_W (MIDX_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_cfg    (i_cfg),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (push_op),
        .o_addr   (push_addr)
    );

    // Operation queue between the halves.
    msfr_queue #(
        .DATA_W (QW),
        .DEPTH  (msfr_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({push_addr, push_op}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (pop)
    );

    // Record storage and result output.
    msfr_back #(
        .MOTORS (MOTORS),
        .MIDX_W (MIDX_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .i_addr    (head_addr),
        .o_pop     (pop),
        .o_rec     (o_rec)
    );

endmodule

`default_nettype wire

@@ rtl/msfr_checker.sv @@
// Port-level checks of the motor status frame receiver, bound to the top.
// Depends on msfr_pkg and motor_status_frame_receiver_core.
`default_nettype none

module msfr_checker #(
    parameter int MOTORS = msfr_pkg::MOTORS_DEFAULT
) (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           i_ready,
    input wire logic [msfr_pkg::IDX_OUT_W-1:0] i_motor_index,
    input wire logic [15:0]                    i_position_raw,
    input wire logic [15:0]                    i_current_raw,
    input wire logic [1:0]                     i_frame_status,
    input wire logic                           i_last_of_frame
);

    localparam logic [msfr_pkg::IDX_OUT_W-1:0] LAST_IDX = msfr_pkg::IDX_OUT_W'(MOTORS - 1);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_motor_index)
            && $stable(i_position_raw) && $stable(i_current_raw)
            && $stable(i_frame_status) && $stable(i_last_of_frame))
        else $error("result changed while stalled");

    // An error result is alone in its frame and carries zeros.
    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_status != msfr_pkg::FS_GOOD |->
            i_last_of_frame && i_motor_index == '0
            && i_position_raw == '0 && i_current_raw == '0)
        else $error("malformed error result");

    // Only the three defined status codes appear.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_frame_status == msfr_pkg::FS_GOOD
            || i_frame_status == msfr_pkg::FS_HDR
            || i_frame_status == msfr_pkg::FS_CRC)
        else $error("undefined frame status");

    // A good frame ends exactly on its final motor record.
    a_good_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_frame_status == msfr_pkg::FS_GOOD |->
            i_last_of_frame == (i_motor_index == LAST_IDX))
        else $error("last marker on wrong record");

endmodule

bind motor_status_frame_receiver_core msfr_checker #(
    .MOTORS (MOTORS)
) u_msfr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_rec.valid),
    .i_ready         (o_rec.ready),
    .i_motor_index   (o_rec.motor_index),
    .i_position_raw  (o_rec.position_raw),
    .i_current_raw   (o_rec.current_raw),
    .i_frame_status  (o_rec.frame_status),
    .i_last_of_frame (o_rec.last_of_frame)
);

`default_nettype wire
